@@ hw/rtl/spr_pkg.sv @@
// Slotted page record store: shared constants, codes and controller/datapath structs.
// No dependencies; every other RTL file of the block imports it.
package spr_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int MAX_SLOTS  = 1024;
    localparam int HEADER_LEN = 6;
    localparam int ENTRY_LEN  = 4;

    localparam int PAGE_AW = $clog2(PAGE_BYTES);
    localparam int SLOT_W  = 10;
    localparam int SLOT_AW = $clog2(MAX_SLOTS);
    localparam int USED_W  = SLOT_AW + 1;
    localparam int LEN_W   = 13;
    localparam int IDX_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 3;
    localparam int CMD_W   = 2;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;

    localparam logic [LEN_W-1:0] PAGE_END  = LEN_W'(PAGE_BYTES);
    localparam logic [USED_W-1:0] SLOTS_MAX = USED_W'(MAX_SLOTS);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_NO_ROOM  = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_NO_SLOT  = 3'd3,
        STAT_REMOVED  = 3'd4,
        STAT_TOO_LONG = 3'd5,
        STAT_PAST_END = 3'd6
    } stat_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_EXEC  = 2'd1,
        FSM_RDOUT = 2'd2
    } fsm_t;

    typedef enum logic [1:0] {
        EMIT_NONE   = 2'd0,
        EMIT_ROW    = 2'd1,
        EMIT_LOOKUP = 2'd2,
        EMIT_READ   = 2'd3
    } emit_t;

    typedef struct packed {
        logic [LEN_W-1:0] off;
        logic [LEN_W-1:0] len;
    } dir_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic  capture;
        logic  start_row;
        logic  byte_step;
        logic  dir_remove;
        logic  page_rd;
        emit_t emit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic row_active;
        logic last;
        logic chk_ok;
        logic out_free;
    } dp_stat_t;

endpackage

@@ hw/rtl/spr_ctrl.sv @@
// Slotted page record store: controller state machine.
// Depends on spr_pkg; drives the datapath through ctrl_cmd_t.
module spr_ctrl import spr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    fsm_t state_reg;
    fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.emit   = EMIT_NONE;
        case (state_reg)
            FSM_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (stat.row_active)
                begin
                    // a final word must find the output register free
                    if (!stat.last || stat.out_free)
                    begin
                        cmd.byte_step = 1'b1;
                        if (stat.last)
                        begin
                            cmd.emit = EMIT_ROW;
                        end
                        state_next = FSM_IDLE;
                    end
                end
                else
                begin
                    case (stat.cmd)
                        CMD_READ:
                        begin
                            if (stat.chk_ok)
                            begin
                                cmd.page_rd = 1'b1;
                                state_next  = FSM_RDOUT;
                            end
                            else if (stat.out_free)
                            begin
                                cmd.emit   = EMIT_LOOKUP;
                                state_next = FSM_IDLE;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit       = EMIT_LOOKUP;
                                cmd.dir_remove = 1'b1;
                                state_next     = FSM_IDLE;
                            end
                        end
                        default:
                        begin
                            // insert or update: open the row, its first byte follows here
                            cmd.start_row = 1'b1;
                        end
                    endcase
                end
            end
            FSM_RDOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = EMIT_READ;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/spr_datapath.sv @@
// Slotted page record store: page and directory memories, page bookkeeping, output register.
// Depends on spr_pkg; steered by spr_ctrl.
module spr_datapath import spr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]    s_tuser,
    input  logic                s_tlast,
    input  logic                m_tready,
    input  ctrl_cmd_t           cmd,
    output dp_stat_t            stat,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [STAT_W-1:0]   m_tuser
);

    logic [BYTE_W-1:0] page_mem [PAGE_BYTES];
    dir_entry_t        dir_mem  [MAX_SLOTS];

    // captured word
    cmd_t              cmd_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    dir_entry_t        dir_q_reg;
    logic [BYTE_W-1:0] page_q_reg;

    logic [USED_W-1:0] slots_used_reg;
    logic [LEN_W-1:0]  free_start_reg;
    logic [LEN_W-1:0]  free_end_reg;
    logic [LEN_W-1:0]  wp_reg;
    logic              row_active_reg;
    logic              row_accepted_reg;
    stat_t             row_status_reg;
    logic [SLOT_W-1:0] row_slot_reg;
    logic [LEN_W-1:0]  row_off_reg;
    logic [LEN_W-1:0]  row_len_reg;

    logic              m_valid_reg;
    stat_t             o_status_reg;
    logic [SLOT_W-1:0] o_slot_reg;
    logic [LEN_W-1:0]  o_len_reg;
    logic [BYTE_W-1:0] o_byte_reg;

    logic              slot_ok;
    logic              no_room;
    logic [LEN_W-1:0]  gap;
    logic [LEN_W:0]    need;
    logic [LEN_W-1:0]  rd_addr;
    logic [LEN_W-1:0]  wr_addr;
    logic [LEN_W-1:0]  new_off;
    stat_t             chk;
    logic              chk_ok;
    logic              ins_ok;
    logic              out_free;
    logic              dir_we;
    logic [SLOT_AW-1:0] dir_wa;
    dir_entry_t        dir_wd;
    logic              page_we;

    assign slot_ok  = {1'b0, slot_reg} < slots_used_reg;
    assign gap      = free_end_reg - free_start_reg;
    assign need     = {1'b0, len_reg} + (LEN_W + 1)'(ENTRY_LEN);
    assign no_room  = (slots_used_reg >= SLOTS_MAX) || (free_end_reg < free_start_reg)
                      || ({1'b0, gap} < need);
    assign rd_addr  = dir_q_reg.off + {1'b0, idx_reg};
    assign wr_addr  = row_off_reg + wp_reg;
    assign new_off  = free_end_reg - len_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        chk = STAT_OK;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (len_reg == '0)
                begin
                    chk = STAT_EMPTY;
                end
                else if (no_room)
                begin
                    chk = STAT_NO_ROOM;
                end
            end
            default:
            begin
                if (!slot_ok)
                begin
                    chk = STAT_NO_SLOT;
                end
                else if (dir_q_reg.len == '0)
                begin
                    chk = STAT_REMOVED;
                end
                else if (cmd_reg == CMD_READ &&
                         ({1'b0, idx_reg} >= dir_q_reg.len || rd_addr >= PAGE_END))
                begin
                    chk = STAT_PAST_END;
                end
                else if (cmd_reg == CMD_UPDATE && len_reg > dir_q_reg.len)
                begin
                    chk = STAT_TOO_LONG;
                end
            end
        endcase
    end

    assign chk_ok = (chk == STAT_OK);
    assign ins_ok = (cmd_reg == CMD_INSERT) && chk_ok;

    assign stat.cmd        = cmd_reg;
    assign stat.row_active = row_active_reg;
    assign stat.last       = last_reg;
    assign stat.chk_ok     = chk_ok;
    assign stat.out_free   = out_free;

    // one directory write port: new entry, shortened entry or cleared entry
    always_comb
    begin
        dir_we = (cmd.start_row || cmd.dir_remove) && chk_ok;
        dir_wa = slot_reg[SLOT_AW-1:0];
        dir_wd.off = dir_q_reg.off;
        dir_wd.len = len_reg;
        if (cmd.dir_remove)
        begin
            dir_wd = '0;
        end
        else if (cmd_reg == CMD_INSERT)
        begin
            dir_wa     = slots_used_reg[SLOT_AW-1:0];
            dir_wd.off = new_off;
        end
    end

    assign page_we = cmd.byte_step && row_accepted_reg && (wp_reg < row_len_reg)
                     && (wr_addr < PAGE_END);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dir_q_reg <= dir_mem[s_tdata[SLOT_AW-1:0]];
        end
        if (dir_we)
        begin
            dir_mem[dir_wa] <= dir_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.page_rd)
        begin
            page_q_reg <= page_mem[rd_addr[PAGE_AW-1:0]];
        end
        if (page_we)
        begin
            page_mem[wr_addr[PAGE_AW-1:0]] <= byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= cmd_t'(s_tuser);
            slot_reg <= s_tdata[SLOT_W-1:0];
            len_reg  <= s_tdata[SLOT_W +: LEN_W];
            idx_reg  <= s_tdata[SLOT_W + LEN_W +: IDX_W];
            byte_reg <= s_tdata[SLOT_W + LEN_W + IDX_W +: BYTE_W];
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_used_reg   <= '0;
            free_start_reg   <= LEN_W'(HEADER_LEN);
            free_end_reg     <= PAGE_END;
            wp_reg           <= '0;
            row_active_reg   <= 1'b0;
            row_accepted_reg <= 1'b0;
            row_status_reg   <= STAT_OK;
            row_slot_reg     <= '0;
            row_off_reg      <= '0;
            row_len_reg      <= '0;
        end
        else if (cmd.start_row)
        begin
            row_active_reg   <= 1'b1;
            row_accepted_reg <= chk_ok;
            row_status_reg   <= chk;
            wp_reg           <= '0;
            row_slot_reg     <= ins_ok ? slots_used_reg[SLOT_W-1:0] : slot_reg;
            row_off_reg      <= ins_ok ? new_off : dir_q_reg.off;
            // too long keeps the old length for the report
            row_len_reg      <= chk_ok ? len_reg : dir_q_reg.len;
            if (ins_ok)
            begin
                free_end_reg   <= new_off;
                slots_used_reg <= slots_used_reg + USED_W'(1);
                free_start_reg <= free_start_reg + LEN_W'(ENTRY_LEN);
            end
        end
        else if (cmd.byte_step)
        begin
            if (last_reg)
            begin
                row_active_reg   <= 1'b0;
                row_accepted_reg <= 1'b0;
                wp_reg           <= '0;
            end
            else if (page_we)
            begin
                wp_reg <= wp_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.emit != EMIT_NONE)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.emit)
            EMIT_ROW:
            begin
                o_status_reg <= row_status_reg;
                o_slot_reg   <= row_slot_reg;
                o_len_reg    <= (row_accepted_reg || row_status_reg == STAT_TOO_LONG)
                                ? row_len_reg : '0;
                o_byte_reg   <= '0;
            end
            EMIT_LOOKUP:
            begin
                o_status_reg <= chk;
                o_slot_reg   <= slot_reg;
                o_len_reg    <= (cmd_reg == CMD_READ && slot_ok) ? dir_q_reg.len : '0;
                o_byte_reg   <= '0;
            end
            EMIT_READ:
            begin
                o_status_reg <= STAT_OK;
                o_slot_reg   <= slot_reg;
                o_len_reg    <= dir_q_reg.len;
                o_byte_reg   <= page_q_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {1'b0, o_byte_reg, o_len_reg, o_slot_reg};

endmodule

@@ hw/rtl/slotted_page_record_store.sv @@
// channel | dir | handshake         | payload
// s       | in  | s_tvalid/s_tready | tdata {data_byte,byte_index,row_length,slot}, tuser, tlast
// m       | out | m_tvalid/m_tready | tdata {read_byte,stored_length,slot_number}, tuser status
//
// One word at a time. A row byte is accepted, then written to the page; the
// first word of an insert or update does the directory lookup/update first.
// A read that finds its byte takes a directory read, then a dependent
// page-memory read; a refused read and a remove need no page read.
// No clearing pass after reset; memories are not reset.
// The result sits in an output register; a word with a result waits while it is full.
//
// Top level: ties spr_ctrl and spr_datapath together. Depends on spr_pkg.
module slotted_page_record_store import spr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // slot, row_length, byte_index, data_byte
    input  logic [CMD_W-1:0]    s_tuser,  // command
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // slot_number, stored_length, read_byte
    output logic [STAT_W-1:0]   m_tuser   // status
);

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    spr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    spr_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .cmd      (ctrl_cmd),
        .stat     (dp_stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ hw/rtl/spr_checker.sv @@
// Slotted page record store: port-level checker and its bind to the top level.
// Depends on spr_pkg; sees the top level's ports only.
module spr_checker import spr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]   m_tuser
);

    // result word held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // one word in flight: ready drops right after an accept
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[30:23] != 8'd0 |-> m_tuser == STAT_OK)
        else $error("read byte returned with failing status");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_NO_SLOT || m_tuser == STAT_REMOVED
                     || m_tuser == STAT_EMPTY || m_tuser == STAT_NO_ROOM)
        |-> m_tdata[22:10] == '0)
        else $error("length reported for missing row");

endmodule

bind slotted_page_record_store spr_checker u_spr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
